FILE: design/grce_pkg.sv
`default_nettype none

package grce_pkg;

    // Event kinds as they appear on the result channel.
    localparam logic [2:0] KIND_BUTTON  = 3'd0;
    localparam logic [2:0] KIND_STICK   = 3'd1;
    localparam logic [2:0] KIND_TRIGGER = 3'd2;
    localparam logic [2:0] KIND_MODE    = 3'd3;
    localparam logic [2:0] KIND_VERSION = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_INPUT_ID  = 1'b0;
    localparam logic CFG_STATUS_ID = 1'b1;

    // Event slots. A report sets one bit per event it causes, and the bits are
    // sent lowest first. Input and status reports use disjoint slots.
    localparam int NUM_SLOTS  = 25;
    localparam int SLOT_W     = 5;
    localparam int NUM_BTN    = 17;

    localparam logic [SLOT_W-1:0] SLOT_BTN_FIRST   = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_BTN_LAST    = 5'd14;
    localparam logic [SLOT_W-1:0] SLOT_STICK_FIRST = 5'd15;
    localparam logic [SLOT_W-1:0] SLOT_STICK_LAST  = 5'd18;
    localparam logic [SLOT_W-1:0] SLOT_TRIG_FIRST  = 5'd19;
    localparam logic [SLOT_W-1:0] SLOT_TRIG_LAST   = 5'd20;
    localparam logic [SLOT_W-1:0] SLOT_MODE        = 5'd21;
    localparam logic [SLOT_W-1:0] SLOT_VERSION     = 5'd22;
    localparam logic [SLOT_W-1:0] SLOT_M1          = 5'd23;
    localparam logic [SLOT_W-1:0] SLOT_M2          = 5'd24;

    localparam logic [SLOT_W-1:0] BTN_M1 = 5'd15;
    localparam logic [SLOT_W-1:0] BTN_M2 = 5'd16;

    localparam logic [7:0] MODE_ON  = 8'd4;
    localparam logic [7:0] MODE_OFF = 8'd0;

    // Everything one report leaves behind for the event sender.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [NUM_BTN-1:0]   btn_now;
        logic [3:0][7:0]      stick;
        logic [1:0][7:0]      trig;
        logic [7:0]           major;
        logic [7:0]           minor;
        logic                 mode_old;
        logic                 mode_new;
    } report_t;

endpackage

`default_nettype wire

FILE: design/grce_decode.sv
`default_nettype none

// Compares a report with the stored controller state, builds its event mask
// and updates the state when the report is accepted.
module grce_decode (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [7:0]          cfg_data,
    input  wire logic                accept,
    input  wire logic [7:0]          report_id,
    input  wire logic [87:0]         payload,
    output grce_pkg::report_t        fresh
);

    logic [7:0]                   input_id_reg;
    logic [7:0]                   status_id_reg;
    logic [grce_pkg::NUM_BTN-1:0] btn_reg;
    logic [grce_pkg::NUM_BTN-1:0] btn_next;
    logic [1:0][7:0]              trig_reg;
    logic [1:0][7:0]              trig_next;
    logic                         mode_reg;
    logic                         mode_next;
    logic [7:0]                   major_reg;
    logic [7:0]                   major_next;
    logic [7:0]                   minor_reg;
    logic [7:0]                   minor_next;

    logic                         is_input;
    logic                         is_status;
    logic [7:0]                   btn_a;
    logic [7:0]                   btn_b;
    logic [7:0]                   extra;
    logic [grce_pkg::NUM_BTN-1:0] btn_now;
    logic                         ver_changed;

    assign cfg_ready = 1'b1;

    assign btn_a = payload[55:48];
    assign btn_b = payload[63:56];
    assign extra = payload[71:64];

    // Button index order: quick, R3, L3, back, start, dpad R/L/D/U, Y, X, B, A,
    // R1, L1, M1, M2.
    assign btn_now = {extra[4], extra[3], btn_b[0], btn_b[1], btn_b[4], btn_b[5],
                      btn_b[6], btn_b[7], btn_a[0], btn_a[1], btn_a[2], btn_a[3],
                      btn_a[4], btn_a[5], btn_a[6], btn_a[7], extra[0]};

    // An id that matches both registers is read as an input report.
    assign is_input  = (report_id == input_id_reg);
    assign is_status = !is_input && (report_id == status_id_reg);

    assign ver_changed = (payload[87:80] != major_reg) || (payload[79:72] != minor_reg);

    always_comb begin
        fresh.mask     = '0;
        fresh.stick    = payload[31:0];
        fresh.trig     = payload[47:32];
        fresh.minor    = payload[79:72];
        fresh.major    = payload[87:80];
        fresh.mode_old = mode_reg;
        fresh.mode_new = extra[2];
        fresh.btn_now  = btn_reg;
        btn_next       = btn_reg;
        trig_next      = trig_reg;
        mode_next      = mode_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        if (is_input) begin
            fresh.mask[14:0]  = btn_now[14:0] ^ btn_reg[14:0];
            fresh.mask[18:15] = 4'hF;
            fresh.mask[19]    = (payload[39:32] != trig_reg[0]);
            fresh.mask[20]    = (payload[47:40] != trig_reg[1]);
            btn_next          = {btn_reg[16:15], btn_now[14:0]};
            trig_next         = payload[47:32];
        end else if (is_status) begin
            fresh.mask[21] = (extra[2] != mode_reg);
            fresh.mask[22] = ver_changed;
            fresh.mask[23] = btn_now[15] ^ btn_reg[15];
            fresh.mask[24] = btn_now[16] ^ btn_reg[16];
            btn_next       = {btn_now[16:15], btn_reg[14:0]};
            mode_next      = extra[2];
            major_next     = payload[87:80];
            minor_next     = payload[79:72];
        end
        fresh.btn_now = btn_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_id_reg  <= 8'd2;
            status_id_reg <= 8'd3;
            btn_reg       <= '0;
            trig_reg      <= '0;
            mode_reg      <= 1'b0;
            major_reg     <= '0;
            minor_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    grce_pkg::CFG_INPUT_ID:  input_id_reg  <= cfg_data;
                    grce_pkg::CFG_STATUS_ID: status_id_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                btn_reg   <= btn_next;
                trig_reg  <= trig_next;
                mode_reg  <= mode_next;
                major_reg <= major_next;
                minor_reg <= minor_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/grce_emit.sv
`default_nettype none

// Holds one decoded report and sends its events lowest slot first, one per
// cycle while m_tready does not stall them, through the result register.
module grce_emit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire grce_pkg::report_t  fresh,
    output logic                    can_take,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata,
    output logic [2:0]              m_tuser,
    output logic                    m_tlast
);

    grce_pkg::report_t               hold_reg;
    logic [grce_pkg::NUM_SLOTS-1:0]  mask_reg;
    logic [grce_pkg::NUM_SLOTS-1:0]  mask_next;
    logic [grce_pkg::NUM_SLOTS-1:0]  mask_rest;
    logic [grce_pkg::SLOT_W-1:0]     sel;
    logic [grce_pkg::SLOT_W-1:0]     ofs;
    logic                            out_free;
    logic                            fire;

    logic                            valid_reg;
    logic                            valid_next;
    logic [2:0]                      kind_reg;
    logic [4:0]                      src_reg;
    logic [7:0]                      v1_reg;
    logic [7:0]                      v2_reg;
    logic                            last_reg;
    logic [2:0]                      kind_next;
    logic [4:0]                      src_next;
    logic [7:0]                      v1_next;
    logic [7:0]                      v2_next;

    // Lowest pending slot.
    always_comb begin
        sel = '0;
        for (int i = grce_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = grce_pkg::SLOT_W'(i);
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - 1'b1);
    assign out_free  = !valid_reg || m_tready;
    assign fire      = out_free && (mask_reg != '0);
    assign can_take  = (mask_reg == '0) || (fire && (mask_rest == '0));
    assign mask_next = load ? fresh.mask : (fire ? mask_rest : mask_reg);

    always_comb begin
        kind_next = grce_pkg::KIND_BUTTON;
        src_next  = sel;
        v1_next   = '0;
        v2_next   = '0;
        ofs       = '0;
        case (sel) inside
            [grce_pkg::SLOT_BTN_FIRST:grce_pkg::SLOT_BTN_LAST]: begin
                v1_next = {7'd0, hold_reg.btn_now[sel]};
            end
            [grce_pkg::SLOT_STICK_FIRST:grce_pkg::SLOT_STICK_LAST]: begin
                ofs       = sel - grce_pkg::SLOT_STICK_FIRST;
                kind_next = grce_pkg::KIND_STICK;
                src_next  = ofs;
                v1_next   = hold_reg.stick[ofs[1:0]];
            end
            [grce_pkg::SLOT_TRIG_FIRST:grce_pkg::SLOT_TRIG_LAST]: begin
                ofs       = sel - grce_pkg::SLOT_TRIG_FIRST;
                kind_next = grce_pkg::KIND_TRIGGER;
                src_next  = ofs;
                v1_next   = hold_reg.trig[ofs[0]];
            end
            grce_pkg::SLOT_MODE: begin
                kind_next = grce_pkg::KIND_MODE;
                src_next  = '0;
                v1_next   = hold_reg.mode_old ? grce_pkg::MODE_ON : grce_pkg::MODE_OFF;
                v2_next   = hold_reg.mode_new ? grce_pkg::MODE_ON : grce_pkg::MODE_OFF;
            end
            grce_pkg::SLOT_VERSION: begin
                kind_next = grce_pkg::KIND_VERSION;
                src_next  = '0;
                v1_next   = hold_reg.major;
                v2_next   = hold_reg.minor;
            end
            grce_pkg::SLOT_M1: begin
                src_next = grce_pkg::BTN_M1;
                v1_next  = {7'd0, hold_reg.btn_now[grce_pkg::BTN_M1]};
            end
            grce_pkg::SLOT_M2: begin
                src_next = grce_pkg::BTN_M2;
                v1_next  = {7'd0, hold_reg.btn_now[grce_pkg::BTN_M2]};
            end
            default: ;
        endcase
    end

    assign valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hold_reg <= fresh;
        end
        if (fire) begin
            kind_reg <= kind_next;
            src_reg  <= src_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            last_reg <= (mask_rest == '0);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'd0, v2_reg, v1_reg, src_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

FILE: design/gamepad_report_change_events.sv
`default_nettype none

// Channel   Dir  Beat contents
// --------  ---  -------------------------------------------------------------
// s_*       in   one controller report: id in tuser, eleven payload bytes
// m_*       out  one change event: kind in tuser, source and values in tdata
// cfg_*     in   one register write: index 0 input report id, 1 status id
//
// A report is compared with the stored state in the cycle it is accepted,
// and the stored state is updated at once. Its events then leave one per
// cycle from the result register; the next report is taken in the cycle its
// predecessor's last event is loaded. Reset clears the stored state and sets
// the ids to 2 and 3. A stall on m_tready holds the result register and the
// pending events; s_tready stays low while the report in hand still has
// events to load, so at most one report waits behind a stalled event.
module gamepad_report_change_events (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Lowest bit up: stick_left_x, stick_left_y, stick_right_x, stick_right_y,
    // trigger_left_in, trigger_right_in, button_byte_a, button_byte_b,
    // extra_byte, version_minor_in, version_major_in.
    input  wire logic [87:0] s_tdata,
    // report_id.
    input  wire logic [7:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Lowest bit up: event_source (5), value_first (8), value_second (8),
    // three zero bits.
    output logic [23:0]      m_tdata,
    // event_kind.
    output logic [2:0]       m_tuser,
    // last_event.
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    grce_pkg::report_t fresh;
    logic              can_take;
    logic              accept;

    assign s_tready = can_take;
    assign accept   = s_tvalid && can_take;

    // Report against stored state: event mask and state update.
    grce_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .report_id (s_tuser),
        .payload   (s_tdata),
        .fresh     (fresh)
    );

    // Serial event sender and result register.
    grce_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .fresh    (fresh),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: bench/gamepad_report_change_events_tb.sv
`default_nettype none

module gamepad_report_change_events_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // After the last expected event, a report that causes no event may still be
    // in flight. One report never causes more than 21 events, so this is ample.
    localparam int DRAIN_TAIL   = 40;
    // The receiver holds off once, for this many cycles, after this many
    // reports have been taken.
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 130;
    // The watchdog ends the run after this many cycles without any beat.
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;
    localparam int PRINT_LIMIT  = 40;

    // Payload bytes in the order they sit on s_tdata, highest byte first, so
    // that the packed struct can be driven onto the bus as it is.
    typedef struct packed {
        logic [7:0] ver_major;
        logic [7:0] ver_minor;
        logic [7:0] extra;
        logic [7:0] btn_b;
        logic [7:0] btn_a;
        logic [7:0] trig_r;
        logic [7:0] trig_l;
        logic [7:0] rs_y;
        logic [7:0] rs_x;
        logic [7:0] ls_y;
        logic [7:0] ls_x;
    } pad_t;

    // One change event as it leaves the block.
    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] source;
        logic [7:0] v1;
        logic [7:0] v2;
        logic       is_last;
    } gp_event_t;

    // One row of the directed script: either a register write or a report.
    // A report row may carry a hand-written expectation of at most one event.
    typedef struct {
        logic       is_cfg;
        logic       reg_idx;
        logic [7:0] reg_val;
        logic [7:0] id;
        pad_t       body;
        logic       typed;
        int         typed_n;
        gp_event_t  typed_ev;
    } script_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;
    logic [7:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data  = '0;

    // Sideband that travels with the report beat: when set, the hand-written
    // expectation replaces the predicted one for that report.
    logic        tag_typed = 1'b0;
    int          tag_count = 0;
    gp_event_t   tag_event = '0;

    gamepad_report_change_events DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of what the block remembers between
    // reports, plus the two report ids as last written.
    // ------------------------------------------------------------------
    logic [16:0] held_buttons = '0;
    logic [7:0]  trig_seen [2] = '{8'd0, 8'd0};
    logic        mode_seen    = 1'b0;
    logic [7:0]  fw_major     = '0;
    logic [7:0]  fw_minor     = '0;
    logic [7:0]  id_input     = 8'd2;
    logic [7:0]  id_status    = 8'd3;

    gp_event_t   report_events [$];   // events of the report being predicted
    gp_event_t   events_due [$];      // events still owed by the block

    int mismatches     = 0;
    int events_checked = 0;
    int reports_taken  = 0;
    int n_input        = 0;
    int n_status       = 0;
    int n_ignored      = 0;
    int most_events    = 0;
    int cfg_writes     = 0;
    int stall_cycles   = 0;
    bit steady         = 1'b0;        // no idling on either side while set
    bit holdoff_done   = 1'b0;

    function automatic gp_event_t mk_event(input logic [2:0] kind, input logic [4:0] src,
                                           input logic [7:0] v1, input logic [7:0] v2,
                                           input logic is_last);
        gp_event_t e;
        e.kind    = kind;
        e.source  = src;
        e.v1      = v1;
        e.v2      = v2;
        e.is_last = is_last;
        return e;
    endfunction

    function automatic pad_t pad(input logic [7:0] lx, ly, rx, ry, tl, tr, ba, bb, ex,
                                 input logic [7:0] vmn, vmj);
        pad_t p;
        p.ls_x      = lx;
        p.ls_y      = ly;
        p.rs_x      = rx;
        p.rs_y      = ry;
        p.trig_l    = tl;
        p.trig_r    = tr;
        p.btn_a     = ba;
        p.btn_b     = bb;
        p.extra     = ex;
        p.ver_minor = vmn;
        p.ver_major = vmj;
        return p;
    endfunction

    // A button yields an event only on an edge against its stored flag.
    function automatic void note_button(input logic now, input logic [4:0] idx);
        if (now != held_buttons[idx]) begin
            held_buttons[idx] = now;
            report_events.push_back(mk_event(grce_pkg::KIND_BUTTON, idx, {7'd0, now}, 8'd0,
                                             1'b0));
        end
    endfunction

    function automatic void note_trigger(input logic [7:0] level, input int idx);
        if (level != trig_seen[idx]) begin
            trig_seen[idx] = level;
            report_events.push_back(mk_event(grce_pkg::KIND_TRIGGER, 5'(idx), level, 8'd0,
                                             1'b0));
        end
    endfunction

    // Works out the events of one report in the order the block sends them and
    // updates the remembered state. The input id is tested first, so a report
    // whose id matches both registers is read as an input report.
    function automatic void predict_report(input logic [7:0] id, input pad_t p);
        int i;
        report_events.delete();
        if (id == id_input) begin
            n_input++;
            note_button(p.extra[0], 5'd0);
            // Byte 7 runs R3 down to dpad up, highest bit first.
            for (i = 0; i < 8; i++)
                note_button(p.btn_a[7 - i], 5'(1 + i));
            // Byte 8: Y, X, B, A from the top nibble, then R1 and L1.
            for (i = 0; i < 4; i++)
                note_button(p.btn_b[7 - i], 5'(9 + i));
            note_button(p.btn_b[1], 5'd13);
            note_button(p.btn_b[0], 5'd14);
            // Sticks are always reported and never stored.
            report_events.push_back(mk_event(grce_pkg::KIND_STICK, 5'd0, p.ls_x, 8'd0, 1'b0));
            report_events.push_back(mk_event(grce_pkg::KIND_STICK, 5'd1, p.ls_y, 8'd0, 1'b0));
            report_events.push_back(mk_event(grce_pkg::KIND_STICK, 5'd2, p.rs_x, 8'd0, 1'b0));
            report_events.push_back(mk_event(grce_pkg::KIND_STICK, 5'd3, p.rs_y, 8'd0, 1'b0));
            note_trigger(p.trig_l, 0);
            note_trigger(p.trig_r, 1);
        end else if (id == id_status) begin
            n_status++;
            if (p.extra[2] != mode_seen) begin
                report_events.push_back(mk_event(grce_pkg::KIND_MODE, 5'd0,
                                                 mode_seen ? grce_pkg::MODE_ON
                                                           : grce_pkg::MODE_OFF,
                                                 p.extra[2] ? grce_pkg::MODE_ON
                                                            : grce_pkg::MODE_OFF,
                                                 1'b0));
                mode_seen = p.extra[2];
            end
            if (p.ver_major != fw_major || p.ver_minor != fw_minor) begin
                fw_major = p.ver_major;
                fw_minor = p.ver_minor;
                report_events.push_back(mk_event(grce_pkg::KIND_VERSION, 5'd0, p.ver_major,
                                                 p.ver_minor, 1'b0));
            end
            note_button(p.extra[3], grce_pkg::BTN_M1);
            note_button(p.extra[4], grce_pkg::BTN_M2);
        end else begin
            n_ignored++;
        end
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Bus monitor. Every beat is seen here at the edge that accepts it, so the
    // predictor runs in beat order and never races the drivers.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        gp_event_t got;
        gp_event_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                if (cfg_index == grce_pkg::CFG_INPUT_ID)
                    id_input = cfg_data;
                else
                    id_status = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                reports_taken++;
                predict_report(s_tuser, pad_t'(s_tdata));
                if (report_events.size() > 0)
                    report_events[$].is_last = 1'b1;
                // A hand-written row overrides the prediction but the state
                // update above still stands.
                if (tag_typed) begin
                    report_events.delete();
                    if (tag_count > 0)
                        report_events.push_back(tag_event);
                end
                if (report_events.size() > most_events)
                    most_events = report_events.size();
                foreach (report_events[i])
                    events_due.push_back(report_events[i]);
            end
            if (m_tvalid && m_tready) begin
                got.kind    = m_tuser;
                got.source  = m_tdata[4:0];
                got.v1      = m_tdata[12:5];
                got.v2      = m_tdata[20:13];
                got.is_last = m_tlast;
                events_checked++;
                if (events_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected event kind %0d source %0d",
                                            got.kind, got.source));
                end else begin
                    want = events_due.pop_front();
                    if (got.kind !== want.kind)
                        flag_mismatch($sformatf("event %0d kind %0d, expected %0d",
                                                events_checked, got.kind, want.kind));
                    if (got.source !== want.source)
                        flag_mismatch($sformatf("event %0d source %0d, expected %0d",
                                                events_checked, got.source, want.source));
                    if (got.v1 !== want.v1)
                        flag_mismatch($sformatf("event %0d value_first %0h, expected %0h",
                                                events_checked, got.v1, want.v1));
                    if (got.v2 !== want.v2)
                        flag_mismatch($sformatf("event %0d value_second %0h, expected %0h",
                                                events_checked, got.v2, want.v2));
                    if (got.is_last !== want.is_last)
                        flag_mismatch($sformatf("event %0d last %0b, expected %0b",
                                                events_checked, got.is_last, want.is_last));
                end
            end
        end
    end

    // The watchdog only counts cycles in which no beat moves on any channel.
    always @(posedge aclk) begin
        if (aresetn && !((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                         (cfg_valid && cfg_ready))) begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat for %0d cycles, %0d events outstanding",
                         STALL_LIMIT, events_due.size());
                $display("[gamepad_report_change_events] ERROR");
                $finish;
            end
        end else begin
            stall_cycles = 0;
        end
    end

    // Result side: ready drops at random, except in steady stretches, and once
    // for a long hold so that the block backs up into its input.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (!holdoff_done && reports_taken >= HOLD_AFTER) begin
                holdoff_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= steady || ($urandom_range(99) >= 13);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    script_row_t script [$];

    function automatic void add_cfg(input logic idx, input logic [7:0] val);
        script_row_t r;
        r.is_cfg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        r.id       = '0;
        r.body     = '0;
        r.typed    = 1'b0;
        r.typed_n  = 0;
        r.typed_ev = '0;
        script.push_back(r);
    endfunction

    function automatic void add_rpt(input logic [7:0] id, input pad_t body,
                                    input logic typed = 1'b0, input int n = 0,
                                    input gp_event_t ev = '0);
        script_row_t r;
        r.is_cfg   = 1'b0;
        r.reg_idx  = 1'b0;
        r.reg_val  = '0;
        r.id       = id;
        r.body     = body;
        r.typed    = typed;
        r.typed_n  = n;
        r.typed_ev = ev;
        script.push_back(r);
    endfunction

    // Offers one report and returns at the edge that takes it. A random gap
    // may come first, with valid low.
    task automatic offer_report(input logic [7:0] id, input pad_t body, input logic typed,
                                input int n, input gp_event_t ev);
        if (!steady && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tuser   <= id;
        s_tdata   <= body;
        s_tvalid  <= 1'b1;
        tag_typed <= typed;
        tag_count <= n;
        tag_event <= ev;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stops offering and waits until every owed event is out and the block
    // has had time to finish a report that owes none.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (events_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        pad_t       body;
        logic [7:0] id;
        logic [7:0] new_in;
        logic [7:0] new_st;
        int         roll;

        // Status reports straight after reset: the first mode change and the
        // first version change each give a single event.
        add_rpt(8'd3, pad(0, 0, 0, 0, 0, 0, 0, 0, 8'h04, 0, 0), 1'b1, 1,
                mk_event(grce_pkg::KIND_MODE, 5'd0, grce_pkg::MODE_OFF, grce_pkg::MODE_ON,
                         1'b1));
        add_rpt(8'd3, pad(0, 0, 0, 0, 0, 0, 0, 0, 8'h04, 8'hFF, 8'hFF), 1'b1, 1,
                mk_event(grce_pkg::KIND_VERSION, 5'd0, 8'hFF, 8'hFF, 1'b1));
        add_rpt(8'd3, pad(0, 0, 0, 0, 0, 0, 0, 0, 8'h1C, 8'hFF, 8'hFF));
        // Nothing changed and the quick bit means nothing in a status report.
        add_rpt(8'd3, pad(0, 0, 0, 0, 0, 0, 0, 0, 8'h1D, 8'hFF, 8'hFF), 1'b1, 0);
        add_rpt(8'd3, pad(0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        // Ids that match neither register are dropped.
        add_rpt(8'h00, '1, 1'b1, 0);
        add_rpt(8'hFF, '1, 1'b1, 0);
        // Input reports from all low to all high and back: the full burst of
        // 21 events in both directions, then sticks alone.
        add_rpt(8'd2, '0);
        add_rpt(8'd2, '1);
        add_rpt(8'd2, '1);
        add_rpt(8'd2, '0);
        add_rpt(8'd2, pad(0, 0, 0, 0, 0, 0, 0, 8'h0C, 8'h1E, 8'h55, 8'hAA));
        add_rpt(8'd2, pad(8'h01, 8'h02, 8'h80, 8'h7F, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h01, 0, 0));
        add_rpt(8'd2, pad(8'hFE, 8'hFD, 8'h7F, 8'h80, 8'h80, 8'hFE, 8'h55, 8'hAA, 8'h00, 0, 0));
        // Extreme ids.
        add_cfg(grce_pkg::CFG_INPUT_ID, 8'h00);
        add_cfg(grce_pkg::CFG_STATUS_ID, 8'hFF);
        add_rpt(8'h00, '1);
        add_rpt(8'hFF, pad(0, 0, 0, 0, 0, 0, 0, 0, 8'h04, 8'h34, 8'h12));
        add_rpt(8'd2, '1, 1'b1, 0);
        add_rpt(8'd3, '1, 1'b1, 0);
        // Both registers equal: the shared id reads as an input report.
        add_cfg(grce_pkg::CFG_INPUT_ID, 8'h80);
        add_cfg(grce_pkg::CFG_STATUS_ID, 8'h80);
        add_rpt(8'h80, pad(8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h0F, 8'hF0, 8'h1F, 8'h99,
                           8'h88));
        add_rpt(8'h80, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                if (i > 0 && !script[i - 1].is_cfg)
                    settle();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end else begin
                offer_report(script[i].id, script[i].body, script[i].typed,
                             script[i].typed_n, script[i].typed_ev);
            end
        end

        // Random phases, each under its own pair of ids. Most reports hit one
        // of the two ids; payloads mostly evolve from the previous report so
        // that buttons, triggers and version both change and hold.
        body = '0;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin new_in = 8'd2;  new_st = 8'd3;  end
                3: begin new_in = 8'($urandom); new_st = new_in; end
                6: begin new_in = 8'hFF; new_st = 8'h00; end
                default: begin
                    new_in = 8'($urandom);
                    new_st = 8'($urandom);
                end
            endcase
            if ($urandom_range(1)) begin
                write_reg(grce_pkg::CFG_INPUT_ID, new_in);
                write_reg(grce_pkg::CFG_STATUS_ID, new_st);
            end else begin
                write_reg(grce_pkg::CFG_STATUS_ID, new_st);
                write_reg(grce_pkg::CFG_INPUT_ID, new_in);
            end
            steady = (ph == 4);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Once, the sender waits for the block to empty completely.
                if (ph == 5 && k == PHASE_ITEMS / 2)
                    settle();
                roll = $urandom_range(99);
                if (roll < 45) begin
                    id = id_input;
                end else if (roll < 85) begin
                    id = id_status;
                end else begin
                    id = 8'($urandom);
                    while (id == id_input || id == id_status)
                        id = 8'($urandom);
                end
                if ($urandom_range(19) == 0) begin
                    body = pad_t'({$urandom, $urandom, 24'($urandom)});
                end else begin
                    body.ls_x = 8'($urandom);
                    body.ls_y = 8'($urandom);
                    body.rs_x = 8'($urandom);
                    body.rs_y = 8'($urandom);
                    if ($urandom_range(1)) begin
                        body.btn_a = 8'($urandom);
                        body.btn_b = 8'($urandom);
                        body.extra = 8'($urandom);
                    end else begin
                        case ($urandom_range(2))
                            0: body.btn_a = body.btn_a ^ (8'd1 << $urandom_range(7));
                            1: body.btn_b = body.btn_b ^ (8'd1 << $urandom_range(7));
                            default: body.extra = body.extra ^ (8'd1 << $urandom_range(7));
                        endcase
                    end
                    if ($urandom_range(1))
                        body.trig_l = 8'($urandom);
                    if ($urandom_range(1))
                        body.trig_r = 8'($urandom);
                    case ($urandom_range(9))
                        0, 1: begin
                            body.ver_major = 8'($urandom);
                            body.ver_minor = 8'($urandom);
                        end
                        2: body.ver_minor = 8'($urandom);
                        3: body.ver_major = 8'($urandom);
                        default: ;
                    endcase
                end
                offer_report(id, body, 1'b0, 0, '0);
            end
        end
        steady = 1'b0;

        settle();
        if (events_due.size() != 0)
            flag_mismatch($sformatf("%0d events never arrived", events_due.size()));
        $display("Run covered %0d reports (%0d input, %0d status, %0d other id), %0d writes.",
                 reports_taken, n_input, n_status, n_ignored, cfg_writes);
        $display("Checked %0d events, at most %0d from one report, %0d mismatches.",
                 events_checked, most_events, mismatches);
        if (mismatches == 0)
            $display("[gamepad_report_change_events] OK");
        else
            $display("[gamepad_report_change_events] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: gamepad_report_change_events.f
design/grce_pkg.sv
design/grce_decode.sv
design/grce_emit.sv
design/gamepad_report_change_events.sv
bench/gamepad_report_change_events_tb.sv
